@@ hw/rtl/pcf_pkg.sv @@
// Package: shared constants, phase type and queue command type for the PNG chunk filter.
`timescale 1ns / 1ps

package pcf_pkg;

	// PNG signature and chunk type codes
	localparam logic [63:0] SIG_VALUE = 64'h89504E470D0A1A0A;
	localparam logic [31:0] T_IHDR    = 32'h49484452;
	localparam logic [31:0] T_PLTE    = 32'h504C5445;
	localparam logic [31:0] T_IDAT    = 32'h49444154;
	localparam logic [31:0] T_IEND    = 32'h49454E44;
	localparam logic [31:0] T_TRNS    = 32'h74524E53;

	// Smallest useful image: signature plus one empty chunk
	localparam logic [31:0] MIN_LEN   = 32'd20;
	localparam logic [4:0]  KEPT_SAT  = 5'd20;

	// Length and CRC overhead of a chunk past its header start, less the header bytes seen
	localparam logic [33:0] SPAN_ADJ  = 34'd5;
	localparam logic [32:0] CRC_BYTES = 33'd4;

	// Command queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_SIG,
		PH_HDR,
		PH_BODY,
		PH_STOP,
		PH_REJ
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOT_PNG = 2'd1,
		ST_SHORT  = 2'd2
	} status_t;

	// One front step worth of output: eight signature or header bytes, one byte, and/or the final status
	typedef struct packed {
		logic        eight;
		logic        one;
		logic        fin;
		status_t     status;
		logic [63:0] data;
	} cmd_t;

	// Queue state seen by its neighbors
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

@@ hw/rtl/pcf_ifs.sv @@
// Interfaces: image byte channel, result channel and configuration write channel.
`timescale 1ns / 1ps

interface pcf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface pcf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic [1:0] status;
	modport source (output valid, output out_byte, output byte_valid, output run_last,
		output status, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input run_last,
		input status, output ready);
endinterface

interface pcf_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] image_length;
	modport source (output valid, output image_length, input ready);
	modport sink (input valid, input image_length, output ready);
endinterface

@@ hw/rtl/pcf_fifo.sv @@
// Command queue between the parsing front and the output back.
`timescale 1ns / 1ps

module pcf_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pcf_pkg::cmd_t       wr_cmd,
	input  logic                pop,
	output pcf_pkg::cmd_t       rd_cmd,
	output pcf_pkg::fifo_stat_t stat
);

	pcf_pkg::cmd_t                 mem [pcf_pkg::FIFO_DEPTH];
	logic [pcf_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [pcf_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [pcf_pkg::FIFO_CW-1:0]   count_q;

	assign stat.full  = (count_q == pcf_pkg::FIFO_CW'(pcf_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_cmd     = mem[rd_ptr_q];

	// Store a pushed command
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == pcf_pkg::FIFO_AW'(pcf_pkg::FIFO_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == pcf_pkg::FIFO_AW'(pcf_pkg::FIFO_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full && !pop)) else $error("push into full command queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty)) else $error("pop from empty command queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pcf_pkg::FIFO_CW'(pcf_pkg::FIFO_DEPTH)) else $error("queue count overflow");

endmodule

@@ hw/rtl/pcf_front.sv @@
// Front: accepts image bytes, parses signature and chunk headers, queues output commands.
`timescale 1ns / 1ps

module pcf_front (
	input  logic                clk,
	input  logic                arst_n,
	pcf_in_if.sink              image,
	pcf_cfg_if.sink             cfg,
	input  pcf_pkg::fifo_stat_t q_stat,
	output logic                push,
	output pcf_pkg::cmd_t       cmd
);

	logic [31:0]     len_q;
	logic [31:0]     pos_q, pos_d;
	pcf_pkg::phase_t phase_q, phase_d;
	logic [63:0]     hbuf_q, hbuf_d;
	logic [2:0]      hcnt_q, hcnt_d;
	logic [32:0]     left_q, left_d;
	logic            keep_q, keep_d;
	logic            end_q, end_d;
	logic [4:0]      kept_q, kept_d;

	logic        take;
	logic [63:0] shifted;
	logic [31:0] clen;
	logic [31:0] ctype;
	logic [33:0] span;
	logic        type_kept;
	logic        eight, one, fin;
	logic [5:0]  kept_sum;

	assign image.ready = !q_stat.full;
	assign cfg.ready   = 1'b1;
	assign take        = image.valid && image.ready;

	assign shifted = {hbuf_q[55:0], image.in_byte};
	assign clen    = shifted[63:32];
	assign ctype   = shifted[31:0];
	assign span    = {2'b00, pos_q} + pcf_pkg::SPAN_ADJ + {2'b00, clen};
	assign type_kept = (ctype == pcf_pkg::T_IHDR) || (ctype == pcf_pkg::T_PLTE) ||
		(ctype == pcf_pkg::T_IDAT) || (ctype == pcf_pkg::T_IEND) ||
		(ctype == pcf_pkg::T_TRNS);

	// Hold the image length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			len_q <= cfg.image_length;
		end
	end

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= pcf_pkg::PH_SIG;
			hbuf_q  <= '0;
			hcnt_q  <= '0;
			left_q  <= '0;
			keep_q  <= 1'b0;
			end_q   <= 1'b0;
			kept_q  <= '0;
		end else begin
			pos_q   <= pos_d;
			phase_q <= phase_d;
			hbuf_q  <= hbuf_d;
			hcnt_q  <= hcnt_d;
			left_q  <= left_d;
			keep_q  <= keep_d;
			end_q   <= end_d;
			kept_q  <= kept_d;
		end
	end

	// Step the parser on each accepted byte inside the image
	always_comb begin
		pos_d   = pos_q;
		phase_d = phase_q;
		hbuf_d  = hbuf_q;
		hcnt_d  = hcnt_q;
		left_d  = left_q;
		keep_d  = keep_q;
		end_d   = end_q;
		kept_d  = kept_q;
		eight   = 1'b0;
		one     = 1'b0;
		fin     = 1'b0;
		kept_sum = '0;
		push    = 1'b0;
		cmd     = '0;
		if (take && (pos_q < len_q)) begin
			pos_d = pos_q + 32'd1;
			unique case (phase_q)
				pcf_pkg::PH_SIG: begin
					hbuf_d = shifted;
					hcnt_d = hcnt_q + 3'd1;
					if (hcnt_q == 3'd7) begin
						hbuf_d = '0;
						hcnt_d = '0;
						if ((shifted == pcf_pkg::SIG_VALUE) && (len_q >= pcf_pkg::MIN_LEN)) begin
							eight   = 1'b1;
							phase_d = pcf_pkg::PH_HDR;
						end else begin
							phase_d = pcf_pkg::PH_REJ;
						end
					end
				end
				pcf_pkg::PH_HDR: begin
					hbuf_d = shifted;
					hcnt_d = hcnt_q + 3'd1;
					if (hcnt_q == 3'd7) begin
						hbuf_d = '0;
						hcnt_d = '0;
						if (span > {2'b00, len_q}) begin
							phase_d = pcf_pkg::PH_STOP;
						end else begin
							keep_d  = type_kept;
							end_d   = (ctype == pcf_pkg::T_IEND);
							left_d  = {1'b0, clen} + pcf_pkg::CRC_BYTES;
							eight   = type_kept;
							phase_d = pcf_pkg::PH_BODY;
						end
					end
				end
				pcf_pkg::PH_BODY: begin
					one = keep_q;
					if (left_q != '0) begin
						left_d = left_q - 33'd1;
					end
					if (left_q < 33'd2) begin
						phase_d = end_q ? pcf_pkg::PH_STOP : pcf_pkg::PH_HDR;
					end
				end
				default: begin
				end
			endcase

			// Count kept bytes, saturating
			kept_sum = {1'b0, kept_q} + (eight ? 6'd8 : (one ? 6'd1 : 6'd0));
			kept_d   = (kept_sum > {1'b0, pcf_pkg::KEPT_SAT}) ? pcf_pkg::KEPT_SAT : kept_sum[4:0];

			fin = (pos_d == len_q);
			cmd.eight = eight;
			cmd.one   = one;
			cmd.fin   = fin;
			cmd.data  = eight ? shifted : {image.in_byte, 56'd0};
			if ((phase_d == pcf_pkg::PH_REJ) || (phase_d == pcf_pkg::PH_SIG) ||
				(len_q < pcf_pkg::MIN_LEN)) begin
				cmd.status = pcf_pkg::ST_NOT_PNG;
			end else if (kept_d < pcf_pkg::KEPT_SAT) begin
				cmd.status = pcf_pkg::ST_SHORT;
			end else begin
				cmd.status = pcf_pkg::ST_OK;
			end
			push = eight || one || fin;
		end
	end

	a_rej_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == pcf_pkg::PH_REJ) |=> (phase_q == pcf_pkg::PH_REJ))
		else $error("left rejected phase");
	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= pcf_pkg::KEPT_SAT) else $error("kept count above saturation");

endmodule

@@ hw/rtl/pcf_back.sv @@
// Back: expands queued commands into result items behind an output register.
`timescale 1ns / 1ps

module pcf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pcf_pkg::cmd_t       rd_cmd,
	input  pcf_pkg::fifo_stat_t q_stat,
	output logic                pop,
	pcf_out_if.source           result
);

	logic [63:0]      data_q;
	logic [3:0]       cnt_q;
	logic             fin_q;
	pcf_pkg::status_t st_q;

	logic       ov_q;
	logic [7:0] obyte_q;
	logic       obv_q;
	logic       olast_q;
	logic [1:0] ost_q;

	logic busy;
	logic advance;
	logic finishing;

	assign busy      = (cnt_q != '0) || fin_q;
	assign advance   = !ov_q || result.ready;
	assign finishing = busy && advance &&
		(((cnt_q == 4'd1) && !fin_q) || ((cnt_q == '0) && fin_q));
	assign pop       = !q_stat.empty && (!busy || finishing);

	assign result.valid      = ov_q;
	assign result.out_byte   = obyte_q;
	assign result.byte_valid = obv_q;
	assign result.run_last   = olast_q;
	assign result.status     = ost_q;

	// Load a command or step through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fin_q <= 1'b0;
		end else if (pop) begin
			cnt_q <= rd_cmd.eight ? 4'd8 : (rd_cmd.one ? 4'd1 : 4'd0);
			fin_q <= rd_cmd.fin;
		end else if (busy && advance) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 4'd1;
			end else begin
				fin_q <= 1'b0;
			end
		end
	end

	// Command payload: shift out bytes from the top
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= rd_cmd.data;
			st_q   <= rd_cmd.status;
		end else if (busy && advance && (cnt_q != '0)) begin
			data_q <= {data_q[55:0], 8'd0};
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (advance) begin
			ov_q <= busy;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (advance && busy) begin
			if (cnt_q != '0) begin
				obyte_q <= data_q[63:56];
				obv_q   <= 1'b1;
				olast_q <= 1'b0;
				ost_q   <= pcf_pkg::ST_OK;
			end else begin
				obyte_q <= 8'd0;
				obv_q   <= 1'b0;
				olast_q <= 1'b1;
				ost_q   <= st_q;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'd8) else $error("byte count of command out of range");

endmodule

@@ hw/rtl/png_ancillary_chunk_filter.sv @@
// Top level: PNG chunk filter, front parser, command queue and output back end.
//
//  channel  role    handshake      payload
//  image    sink    valid/ready    in_byte
//  result   source  valid/ready    out_byte, byte_valid, run_last, status
//  cfg      sink    valid/ready    image_length (ready always high)
//
// One byte request is taken per cycle while the command queue has room.
// A kept chunk header expands into eight results, one per cycle from the back end while result is ready;
// during such a burst the four-entry queue fills and then holds off new bytes.
// The status result comes after the last kept byte; a request's first result passes
// through the queue and the back end's command registers into the output register.
// Reset (arst_n low, asynchronous) clears parser state, the queue and image_length.
`timescale 1ns / 1ps

module png_ancillary_chunk_filter (
	input  logic      clk,
	input  logic      arst_n,
	pcf_in_if.sink    image,
	pcf_out_if.source result,
	pcf_cfg_if.sink   cfg
);

	logic                push;
	logic                pop;
	pcf_pkg::cmd_t       wr_cmd;
	pcf_pkg::cmd_t       rd_cmd;
	pcf_pkg::fifo_stat_t q_stat;

	pcf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.image  (image),
		.cfg    (cfg),
		.q_stat (q_stat),
		.push   (push),
		.cmd    (wr_cmd)
	);

	pcf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.stat   (q_stat)
	);

	pcf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_cmd (rd_cmd),
		.q_stat (q_stat),
		.pop    (pop),
		.result (result)
	);

endmodule

@@ bench/tb.sv @@
// Testbench for the PNG chunk filter: directed table, then chunk-structured random bytes.
`timescale 1ns / 1ps

module tb;

	localparam int SETTLE_CYCLES   = 16;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int RANDOM_BYTES    = 260;
	localparam int MAX_GAP         = 19;

	// Ancillary chunk type used as a dropped example
	localparam logic [31:0] T_TEXT = 32'h74455874;

	typedef enum logic {
		ROW_LENGTH,
		ROW_BYTE
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [31:0]      value;
		logic             typed;
		pcf_pkg::status_t status;
	} stim_row_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             byte_valid;
		logic             run_last;
		pcf_pkg::status_t status;
	} filter_result_t;

	// Zero length swallows bytes, a partial signature ends as not-a-PNG, then the signature
	// completes and an empty gAMA chunk is dropped, leaving too few bytes kept.
	localparam stim_row_t DIRECTED [25] = '{
		'{ROW_LENGTH, 32'd0,  1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'hFF, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h00, 1'b0, pcf_pkg::ST_OK},
		'{ROW_LENGTH, 32'd4,  1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h89, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h50, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h4E, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h47, 1'b1, pcf_pkg::ST_NOT_PNG},
		'{ROW_LENGTH, 32'd20, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h0D, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h0A, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h1A, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h0A, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h00, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h00, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h00, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h00, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h67, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h41, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h4D, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h41, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'hFF, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h00, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'hFF, 1'b0, pcf_pkg::ST_OK},
		'{ROW_BYTE,   32'h00, 1'b1, pcf_pkg::ST_SHORT}
	};

	logic clk;
	logic arst_n;

	pcf_in_if  image_ch ();
	pcf_out_if result_ch ();
	pcf_cfg_if cfg_ch ();

	png_ancillary_chunk_filter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.image  (image_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Filter state mirrored by the predictor
	logic [31:0]     length_reg;
	logic [31:0]     scan_pos;
	pcf_pkg::phase_t scan_phase;
	logic [63:0]     hdr_shift;
	logic [3:0]      hdr_fill;
	logic [32:0]     body_left;
	logic            keep_body;
	logic            in_end_chunk;
	logic [4:0]      kept_total;

	filter_result_t filtered_stream[$];
	logic [7:0]     chunk_buf[$];
	int unsigned    fail_count;
	logic           send_steady;
	logic           hold_off_armed;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Queue one kept byte and count it toward the minimum
	task automatic emit_byte(input logic [7:0] b);
		filtered_stream.push_back('{out_byte: b, byte_valid: 1'b1, run_last: 1'b0,
			status: pcf_pkg::ST_OK});
		if (kept_total < pcf_pkg::KEPT_SAT)
			kept_total++;
	endtask

	task automatic emit_header(input logic [63:0] v);
		for (int s = 7; s >= 0; s--)
			emit_byte(v[s*8 +: 8]);
	endtask

	// Advance the filter by one accepted image byte
	task automatic filter_byte(input logic [7:0] b);
		logic [31:0]      at;
		logic [31:0]      ctype;
		logic [63:0]      chunk_end;
		pcf_pkg::status_t st;
		if (scan_pos >= length_reg)
			return;
		at = scan_pos;
		scan_pos++;
		case (scan_phase)
			pcf_pkg::PH_SIG: begin
				hdr_shift = {hdr_shift[55:0], b};
				hdr_fill++;
				if (hdr_fill == 4'd8) begin
					if (hdr_shift == pcf_pkg::SIG_VALUE && length_reg >= pcf_pkg::MIN_LEN) begin
						emit_header(hdr_shift);
						scan_phase = pcf_pkg::PH_HDR;
					end else begin
						scan_phase = pcf_pkg::PH_REJ;
					end
					hdr_shift = '0;
					hdr_fill  = '0;
				end
			end
			pcf_pkg::PH_HDR: begin
				hdr_shift = {hdr_shift[55:0], b};
				hdr_fill++;
				if (hdr_fill == 4'd8) begin
					ctype     = hdr_shift[31:0];
					chunk_end = {32'd0, at} - 64'd7 + {32'd0, hdr_shift[63:32]} + 64'd12;
					hdr_fill  = '0;
					// stop on a chunk that runs past the image
					if (chunk_end > {32'd0, length_reg}) begin
						scan_phase = pcf_pkg::PH_STOP;
					end else begin
						keep_body    = ctype inside {pcf_pkg::T_IHDR, pcf_pkg::T_PLTE,
							pcf_pkg::T_IDAT, pcf_pkg::T_IEND, pcf_pkg::T_TRNS};
						in_end_chunk = (ctype == pcf_pkg::T_IEND);
						body_left    = {1'b0, hdr_shift[63:32]} + 33'd4;
						if (keep_body)
							emit_header(hdr_shift);
						scan_phase = pcf_pkg::PH_BODY;
					end
					hdr_shift = '0;
				end
			end
			pcf_pkg::PH_BODY: begin
				if (keep_body)
					emit_byte(b);
				if (body_left != 0)
					body_left--;
				if (body_left == 0)
					scan_phase = in_end_chunk ? pcf_pkg::PH_STOP : pcf_pkg::PH_HDR;
			end
			default: begin
			end
		endcase
		// close the run on the image's last byte
		if (scan_pos == length_reg) begin
			if (scan_phase == pcf_pkg::PH_REJ || scan_phase == pcf_pkg::PH_SIG ||
				length_reg < pcf_pkg::MIN_LEN)
				st = pcf_pkg::ST_NOT_PNG;
			else if (kept_total < pcf_pkg::KEPT_SAT)
				st = pcf_pkg::ST_SHORT;
			else
				st = pcf_pkg::ST_OK;
			filtered_stream.push_back('{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1,
				status: st});
		end
	endtask

	// Offer one byte after a random gap and predict once it is taken
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if ($urandom_range(0, 29) == 0)
			send_steady = !send_steady;
		gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			image_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		image_ch.valid   <= 1'b1;
		image_ch.in_byte <= b;
		do @(posedge clk); while (!image_ch.ready);
		filter_byte(b);
	endtask

	// Drain all pending results, then let the pipeline empty
	task automatic settle();
		image_ch.valid <= 1'b0;
		while (filtered_stream.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_length(input logic [31:0] v);
		settle();
		cfg_ch.valid        <= 1'b1;
		cfg_ch.image_length <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		length_reg = v;
	endtask

	task automatic build_header(input logic [31:0] clen, input logic [31:0] ctype);
		for (int i = 3; i >= 0; i--)
			chunk_buf.push_back(clen[i*8 +: 8]);
		for (int i = 3; i >= 0; i--)
			chunk_buf.push_back(ctype[i*8 +: 8]);
	endtask

	// Header, data and CRC of one chunk with random content
	task automatic build_chunk(input logic [31:0] clen, input logic [31:0] ctype);
		build_header(clen, ctype);
		for (int i = 0; i < int'(clen) + 4; i++)
			chunk_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	function automatic logic [31:0] pick_type();
		logic [31:0] kept_types [4];
		kept_types = '{pcf_pkg::T_IHDR, pcf_pkg::T_PLTE, pcf_pkg::T_IDAT, pcf_pkg::T_TRNS};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return kept_types[$urandom_range(0, 3)];
			6: return kept_types[$urandom_range(0, 3)] ^ (32'd1 << $urandom_range(0, 31));
			7: return T_TEXT;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_length();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
	endfunction

	task automatic check_result();
		filter_result_t want;
		if (filtered_stream.size() == 0) begin
			$error("unexpected result: out_byte %0h byte_valid %0b run_last %0b status %0d",
				result_ch.out_byte, result_ch.byte_valid, result_ch.run_last, result_ch.status);
			fail_count++;
			return;
		end
		want = filtered_stream.pop_front();
		if (result_ch.out_byte !== want.out_byte) begin
			$error("out_byte: expected %0h, actual %0h", want.out_byte, result_ch.out_byte);
			fail_count++;
		end
		if (result_ch.byte_valid !== want.byte_valid) begin
			$error("byte_valid: expected %0b, actual %0b", want.byte_valid,
				result_ch.byte_valid);
			fail_count++;
		end
		if (result_ch.run_last !== want.run_last) begin
			$error("run_last: expected %0b, actual %0b", want.run_last, result_ch.run_last);
			fail_count++;
		end
		if (result_ch.status !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, result_ch.status);
			fail_count++;
		end
	endtask

	// Result side: random stalls, steady stretches and one long hold-off
	initial begin : result_side
		int unsigned stall;
		logic        steady;
		steady = 1'b0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_armed) begin
				hold_off_armed = 1'b0;
				stall = HOLD_OFF_CYCLES;
			end else begin
				if ($urandom_range(0, 29) == 0)
					steady = !steady;
				stall = steady ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			check_result();
		end
	end

	// Image side: reset, directed table, random chunk segments, closing sequence
	initial begin : image_side
		filter_result_t tail;
		logic [7:0]     segment[$];
		logic [7:0]     carry[$];
		logic [31:0]    clen;
		int unsigned    random_sent;
		int unsigned    seg_index;
		int unsigned    cut;
		arst_n              <= 1'b0;
		image_ch.valid      <= 1'b0;
		image_ch.in_byte    <= 8'h00;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.image_length <= 32'd0;
		length_reg     = '0;
		scan_pos       = '0;
		scan_phase     = pcf_pkg::PH_SIG;
		hdr_shift      = '0;
		hdr_fill       = '0;
		body_left      = '0;
		keep_body      = 1'b0;
		in_end_chunk   = 1'b0;
		kept_total     = '0;
		fail_count     = 0;
		send_steady    = 1'b0;
		hold_off_armed = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table; typed rows carry their own status
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_LENGTH) begin
				set_length(DIRECTED[i].value);
			end else begin
				send_byte(DIRECTED[i].value[7:0]);
				if (DIRECTED[i].typed) begin
					tail = filtered_stream.pop_back();
					tail.status = DIRECTED[i].status;
					filtered_stream.push_back(tail);
				end
			end
		end

		// random segments of whole chunks, sometimes cut inside the next header
		random_sent = 0;
		seg_index   = 0;
		while (random_sent < RANDOM_BYTES) begin
			segment = carry;
			carry.delete();
			repeat ($urandom_range(1, 4)) begin
				chunk_buf.delete();
				build_chunk(pick_length(), pick_type());
				foreach (chunk_buf[i])
					segment.push_back(chunk_buf[i]);
			end
			if ($urandom_range(0, 4) == 0) begin
				chunk_buf.delete();
				build_chunk(pick_length(), pick_type());
				cut = $urandom_range(1, 7);
				repeat (cut)
					segment.push_back(chunk_buf.pop_front());
				carry = chunk_buf;
			end
			// drop a few bytes under a lowered length
			if ($urandom_range(0, 5) == 0) begin
				set_length($urandom_range(0, scan_pos));
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom_range(0, 255)));
			end
			set_length(scan_pos + segment.size());
			if (seg_index == 1)
				hold_off_armed = 1'b1;
			foreach (segment[i])
				send_byte(segment[i]);
			random_sent += segment.size();
			// bytes past the end of the image
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom_range(0, 255)));
			seg_index++;
		end

		// largest image length, then one of the ways parsing stops
		set_length(32'hFFFF_FFFF);
		segment = carry;
		repeat (2) begin
			chunk_buf.delete();
			build_chunk(pick_length(), pick_type());
			foreach (chunk_buf[i])
				segment.push_back(chunk_buf[i]);
		end
		foreach (segment[i])
			send_byte(segment[i]);
		chunk_buf.delete();
		case ($urandom_range(0, 2))
			0: begin
				build_chunk($urandom_range(0, 4), pcf_pkg::T_IEND);
			end
			1: begin
				build_header(32'hFFFF_FFFF, pcf_pkg::T_IDAT);
			end
			default: begin
				// chunk overruns the image by one byte
				clen = $urandom_range(0, 8);
				set_length(scan_pos + clen + 32'd11);
				build_chunk(clen, pcf_pkg::T_IDAT);
				void'(chunk_buf.pop_back());
			end
		endcase
		foreach (chunk_buf[i])
			send_byte(chunk_buf[i]);
		repeat (4) send_byte(8'($urandom_range(0, 255)));
		set_length(scan_pos + 32'd2);
		repeat (2) send_byte(8'($urandom_range(0, 255)));

		settle();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
